// File: hw/rtl/pidm_pkg.sv
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared constants and types for the PWM input duty meter.
// ----------------------------------------------------------------------------
package pidm_pkg;

   // default width of the free-running capture counter
   localparam int DefCountBits = 16;

   // duty scale and number of quotient bits (quotient never exceeds 100)
   localparam int DutyScale    = 100;
   localparam int QuotBits     = 7;
   localparam int StepBits     = $clog2(QuotBits);

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } pidm_div_status_type;

endpackage

// File: hw/rtl/pidm_divider.sv
// ----------------------------------------------------------------------------
// pidm_divider
// Restoring divider: one shared compare/subtract unit, one quotient bit per
// cycle, QuotBits restoring steps per division. The quotient must fit in QuotBits.
// ----------------------------------------------------------------------------
module pidm_divider import pidm_pkg::*; #(
   parameter int COUNT_BITS = DefCountBits
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [COUNT_BITS+QuotBits-1:0] numerator,
   input  logic [COUNT_BITS:0]            divisor,
   output pidm_div_status_type            status,
   output logic [QuotBits-1:0]            quotient
);

   localparam int WideBits = COUNT_BITS + QuotBits;

   logic [WideBits-1:0] rem_ff, rem_in;
   logic [WideBits-1:0] dsh_ff, dsh_in;
   logic [QuotBits-1:0] quot_ff, quot_in;
   logic [StepBits-1:0] step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                fits;

   // shared compare unit
   assign fits = (rem_ff >= dsh_ff);

   // next-state logic: load on start, else one restoring step while busy
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numerator;
         dsh_in  = {divisor, {(QuotBits-1){1'b0}}};
         quot_in = '0;
         step_in = StepBits'(QuotBits - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QuotBits-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - StepBits'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

// File: hw/rtl/pwm_input_duty_meter.sv
// ----------------------------------------------------------------------------
// pwm_input_duty_meter
// Input-capture duty-cycle meter with a serial duty divider.
// ----------------------------------------------------------------------------
// Each request transaction carries one capture timestamp. Captures alternate
// rising/falling starting with rising after reset; the interval since the
// previous capture (modulo 2^COUNT_BITS) becomes the low time on a rising
// capture and the high time on a falling one. One response transaction is
// returned per capture with on, off and total times, the duty percentage
// floor(on*100/total) and the edge expected next. The interval update is made
// at the accepting edge; the sequencer then loads the divider in its start
// state, 7 restoring-division steps run through the single shared
// compare/subtract unit, and the response is registered. req_stall is high
// from the accepting edge until that response is registered, and longer
// while a finished response is held by rsp_stall, so no new capture is taken
// before the previous capture's response is registered.
// ----------------------------------------------------------------------------
module pwm_input_duty_meter import pidm_pkg::*; #(
   parameter int COUNT_BITS = DefCountBits
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COUNT_BITS-1:0] req_capture_time,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_BITS-1:0] rsp_on_period,
   output logic [COUNT_BITS-1:0] rsp_off_period,
   output logic [COUNT_BITS:0]   rsp_total_period,
   output logic [QuotBits-1:0]   rsp_duty_percent,
   output logic                  rsp_duty_valid,
   output logic                  rsp_expect_rising
);

   localparam int WideBits = COUNT_BITS + QuotBits;

   // sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  phase_ff, phase_in;
   logic [COUNT_BITS-1:0] last_ff, last_in;
   logic [COUNT_BITS-1:0] high_ff, high_in;
   logic [COUNT_BITS-1:0] low_ff, low_in;

   logic                  out_valid_ff, out_valid_in;
   logic [COUNT_BITS-1:0] out_on_ff, out_off_ff;
   logic [COUNT_BITS:0]   out_total_ff;
   logic [QuotBits-1:0]   out_duty_ff;
   logic                  out_dvalid_ff, out_rising_ff;

   logic                  req_take;
   logic                  slot_free;
   logic                  load_out;
   logic                  div_start;
   logic [COUNT_BITS-1:0] delta;
   logic [COUNT_BITS:0]   total;
   logic                  total_nz;
   logic [WideBits-1:0]   scaled_high;
   logic [QuotBits-1:0]   div_quot;
   pidm_div_status_type   div_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !out_valid_ff || !rsp_stall;

   // interval and divider operands
   assign delta       = req_capture_time - last_ff;
   assign total       = {1'b0, high_ff} + {1'b0, low_ff};
   assign total_nz    = (total != '0);
   assign scaled_high = WideBits'(high_ff) * WideBits'(DutyScale);
   assign div_start   = (state_ff == ST_START);

   pidm_divider #(
      .COUNT_BITS(COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numerator(scaled_high),
      .divisor  (total),
      .status   (div_status),
      .quotient (div_quot)
   );

   // sequencer and edge-phase state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (!phase_ff) begin
                  low_in = delta;
               end else begin
                  high_in = delta;
               end
               phase_in = !phase_ff;
               last_in  = req_capture_time;
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (slot_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   // control and measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         last_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_on_ff     <= high_ff;
         out_off_ff    <= low_ff;
         out_total_ff  <= total;
         out_duty_ff   <= total_nz ? div_quot : '0;
         out_dvalid_ff <= total_nz;
         out_rising_ff <= !phase_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_on_period     = out_on_ff;
   assign rsp_off_period    = out_off_ff;
   assign rsp_total_period  = out_total_ff;
   assign rsp_duty_percent  = out_duty_ff;
   assign rsp_duty_valid    = out_dvalid_ff;
   assign rsp_expect_rising = out_rising_ff;

   // checks
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> req_stall)
      else $error("divider busy while request side is open");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_START))
      else $error("accepted capture did not start the divider");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dvalid_ff) |-> (out_duty_ff <= QuotBits'(DutyScale)))
      else $error("duty percentage above full scale");

   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_dvalid_ff) |-> (out_duty_ff == '0 && out_total_ff == '0))
      else $error("zero-total response carries a duty value");

endmodule
